/* sv/lzw_compressor_macros.svh */
// Assertion helpers shared by the RTL files
`ifndef LZW_COMPRESSOR_MACROS_SVH
`define LZW_COMPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LZW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzw assertion failed");

// Next-cycle implication, checked outside reset
`define LZW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzw assertion failed");

`endif

/* sv/lzw_pkg.sv */
package lzw_pkg;

    localparam int MAX_CODE_BITS  = 12;
    localparam int INIT_CODE_BITS = 9;
    localparam int DICT_DEPTH     = 1 << MAX_CODE_BITS;
    localparam int CHILD_AW       = MAX_CODE_BITS + 8;
    localparam int CHILD_DEPTH    = 1 << CHILD_AW;
    localparam int KEY_W          = MAX_CODE_BITS + 8;
    localparam int NEXT_W         = MAX_CODE_BITS + 1;
    localparam int ACC_W          = KEY_W;
    localparam int CNT_W          = 5;
    localparam int APB_ADDR_W     = 3;

    localparam logic [NEXT_W-1:0] FIRST_FREE = NEXT_W'(257);
    localparam logic [3:0]        WIDTH_INIT = 4'(INIT_CODE_BITS);
    localparam logic [3:0]        WIDTH_MAX  = 4'(MAX_CODE_BITS);
    localparam logic [7:0]        HDR_BYTE   = 8'(INIT_CODE_BITS);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic REG_MAX_WIDTH = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LOOK,
        ST_VERIFY,
        ST_EMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_push;

endpackage

/* sv/lzw_if.sv */
interface lzw_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface lzw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* sv/lzw_ram.sv */
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/lzw_apb.sv */
module lzw_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lzw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [3:0]                     o_max_width
);
    import lzw_pkg::*;

    logic [3:0] r_max_width;
    logic       w_sel_max;

    assign w_sel_max = (paddr[2] == REG_MAX_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width <= WIDTH_MAX;
        end else if (psel && penable && pwrite && w_sel_max) begin
            r_max_width <= pwdata[3:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = w_sel_max ? {28'd0, r_max_width} : 32'd0;
    assign o_max_width = r_max_width;
endmodule

/* sv/lzw_outq.sv */
module lzw_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lzw_pkg::t_push    i_push,
    output logic              o_room,
    lzw_out_if.source         o_out
);
    import lzw_pkg::*;

    logic [8:0] r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_count;
    logic       w_pop;

    assign w_pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= {i_push.data, i_push.last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_count <= r_count + 3'(i_push.valid) - 3'(w_pop);
        end
    end

    // an item yields at most three bytes
    assign o_room            = (r_count <= 3'd1);
    assign o_out.valid       = (r_count != 3'd0);
    assign o_out.out_byte    = r_mem[r_rp][8:1];
    assign o_out.last_of_run = r_mem[r_rp][0];

`include "lzw_compressor_macros.svh"

    `LZW_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push.valid, r_count != 3'd4)
    `LZW_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_push.valid && !w_pop,
        r_count == $past(r_count) + 3'd1)
    `LZW_ASSERT_NOW(a_empty_ptrs, i_clk, i_rst_n, r_count == 3'd0, r_wp == r_rp)
endmodule

/* sv/lzw_compressor.sv */
// LZW compressor with variable code width, codes packed LSB first.
// i_in carries one item per handshake: a data byte (kind 0) or an end mark
// (kind 1). o_out carries the compressed stream one byte per handshake, with
// last_of_run set on the final byte caused by an input item. Each stream
// opens with a header byte of 9. An end mark flushes the open match and any
// partial byte, then clears the stream state; max_code_width persists.
// Configuration sits behind the APB port, register 0 at address 0.
// Flow: an accepted item passes ST_HDR, then ST_DONE when a byte only opens a
// match; ST_LOOK, ST_VERIFY and ST_DONE on a probe hit; ST_LOOK, ST_VERIFY,
// ST_EMIT and ST_DONE on a miss; ST_EMIT and ST_DONE for an end mark. The
// next item is taken only back in ST_IDLE. A dictionary probe reads the child
// memory (indexed by match code and byte), then the entry memory at the code
// found there to confirm the key, as two dependent registered memory reads;
// ST_EMIT repeats once per packed byte leaving the bit accumulator.
// Results wait in a four-deep queue; a new item is taken only while that queue
// has room for three bytes, so a stalled receiver halts input once fewer than
// three entries are free. Reset is synchronous and needs no clearing pass: a
// probe hit is trusted only if the code lies in the live range and its key
// matches.
module lzw_compressor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lzw_in_if.sink                         i_in,
    lzw_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lzw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import lzw_pkg::*;

    t_state                   r_state, n_state;
    logic                     r_kind, n_kind;
    logic [7:0]               r_byte, n_byte;
    logic [MAX_CODE_BITS-1:0] r_match, n_match;
    logic                     r_match_valid, n_match_valid;
    logic                     r_header_sent, n_header_sent;
    logic [NEXT_W-1:0]        r_next_code, n_next_code;
    logic [3:0]               r_code_width, n_code_width;
    logic [6:0]               r_pend, n_pend;
    logic [2:0]               r_pcnt, n_pcnt;
    logic [ACC_W-1:0]         r_acc, n_acc;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_hold_valid, n_hold_valid;
    logic [7:0]               r_hold_byte, n_hold_byte;

    logic [3:0]               w_max_width;
    logic [3:0]               w_limit;
    logic                     w_room;
    logic                     w_accept;
    t_push                    w_push;
    logic                     w_emit;
    logic [7:0]               w_emit_byte;
    logic [ACC_W-1:0]         w_code_bits;
    logic [ACC_W-1:0]         w_mask;
    logic                     w_found;

    logic                     w_child_re;
    logic                     w_dict_we;
    logic [MAX_CODE_BITS-1:0] w_child_rdata;
    logic                     w_entry_re;
    logic [KEY_W-1:0]         w_entry_rdata;

    lzw_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_width (w_max_width)
    );

    // child code of (match, byte); stale words are screened by the key check
    lzw_ram #(.WIDTH(MAX_CODE_BITS), .DEPTH(CHILD_DEPTH)) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (w_dict_we),
        .i_waddr ({r_match, r_byte}),
        .i_wdata (r_next_code[MAX_CODE_BITS-1:0]),
        .i_re    (w_child_re),
        .i_raddr ({r_match, r_byte}),
        .o_rdata (w_child_rdata)
    );

    // key (prefix, byte) stored at each code
    lzw_ram #(.WIDTH(KEY_W), .DEPTH(DICT_DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_dict_we),
        .i_waddr (r_next_code[MAX_CODE_BITS-1:0]),
        .i_wdata ({r_match, r_byte}),
        .i_re    (w_entry_re),
        .i_raddr (w_child_rdata),
        .o_rdata (w_entry_rdata)
    );

    lzw_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_out   (o_out)
    );

    always_comb begin
        priority if (w_max_width < WIDTH_INIT) begin
            w_limit = WIDTH_INIT;
        end else if (w_max_width > WIDTH_MAX) begin
            w_limit = WIDTH_MAX;
        end else begin
            w_limit = w_max_width;
        end
    end

    assign i_in.ready = (r_state == ST_IDLE) && w_room;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_mask      = (ACC_W'(1) << r_code_width) - ACC_W'(1);
    assign w_code_bits = ((ACC_W'(r_match) & w_mask) << r_pcnt) | ACC_W'(r_pend);

    assign w_found = (w_child_rdata >= FIRST_FREE[MAX_CODE_BITS-1:0])
                  && ({1'b0, w_child_rdata} < r_next_code)
                  && (w_entry_rdata == {r_match, r_byte});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_match_valid <= 1'b0;
            r_header_sent <= 1'b0;
            r_next_code   <= FIRST_FREE;
            r_code_width  <= WIDTH_INIT;
            r_match       <= '0;
            r_pend        <= '0;
            r_pcnt        <= '0;
            r_hold_valid  <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state       <= n_state;
            r_match_valid <= n_match_valid;
            r_header_sent <= n_header_sent;
            r_next_code   <= n_next_code;
            r_code_width  <= n_code_width;
            r_match       <= n_match;
            r_pend        <= n_pend;
            r_pcnt        <= n_pcnt;
            r_hold_valid  <= n_hold_valid;
            r_cnt         <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_byte      <= n_byte;
        r_acc       <= n_acc;
        r_hold_byte <= n_hold_byte;
    end

    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_byte        = r_byte;
        n_match       = r_match;
        n_match_valid = r_match_valid;
        n_header_sent = r_header_sent;
        n_next_code   = r_next_code;
        n_code_width  = r_code_width;
        n_pend        = r_pend;
        n_pcnt        = r_pcnt;
        n_acc         = r_acc;
        n_cnt         = r_cnt;
        n_hold_valid  = r_hold_valid;
        n_hold_byte   = r_hold_byte;
        w_push        = '0;
        w_emit        = 1'b0;
        w_emit_byte   = '0;
        w_child_re    = 1'b0;
        w_entry_re    = 1'b0;
        w_dict_we     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_kind  = i_in.kind;
                    n_byte  = i_in.data_byte;
                    n_state = ST_HDR;
                end
            end
            ST_HDR: begin
                if (!r_header_sent) begin
                    w_emit        = 1'b1;
                    w_emit_byte   = HDR_BYTE;
                    n_header_sent = 1'b1;
                end
                priority if (r_kind == KIND_END) begin
                    if (r_match_valid) begin
                        n_acc = w_code_bits;
                        n_cnt = CNT_W'(r_pcnt) + CNT_W'(r_code_width);
                    end else begin
                        n_acc = ACC_W'(r_pend);
                        n_cnt = CNT_W'(r_pcnt);
                    end
                    n_state = ST_EMIT;
                end else if (!r_match_valid) begin
                    n_match       = MAX_CODE_BITS'(r_byte);
                    n_match_valid = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    w_child_re = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                w_entry_re = 1'b1;
                n_state    = ST_VERIFY;
            end
            ST_VERIFY: begin
                if (w_found) begin
                    n_match = w_child_rdata;
                    n_state = ST_DONE;
                end else begin
                    n_acc   = w_code_bits;
                    n_cnt   = CNT_W'(r_pcnt) + CNT_W'(r_code_width);
                    n_match = MAX_CODE_BITS'(r_byte);
                    // grow the width first, or freeze at the limit
                    if (r_next_code == (NEXT_W'(1) << r_code_width)) begin
                        if (r_code_width < w_limit) begin
                            n_code_width = r_code_width + 4'd1;
                            w_dict_we    = !r_next_code[MAX_CODE_BITS];
                        end
                    end else begin
                        w_dict_we = !r_next_code[MAX_CODE_BITS];
                    end
                    if (w_dict_we) begin
                        n_next_code = r_next_code + NEXT_W'(1);
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_cnt >= CNT_W'(8)) begin
                    w_emit      = 1'b1;
                    w_emit_byte = r_acc[7:0];
                    n_acc       = r_acc >> 8;
                    n_cnt       = r_cnt - CNT_W'(8);
                end else begin
                    if (r_kind == KIND_END) begin
                        if (r_cnt != '0) begin
                            w_emit      = 1'b1;
                            w_emit_byte = r_acc[7:0];
                        end
                        n_next_code   = FIRST_FREE;
                        n_code_width  = WIDTH_INIT;
                        n_match       = '0;
                        n_match_valid = 1'b0;
                        n_header_sent = 1'b0;
                        n_pend        = '0;
                        n_pcnt        = '0;
                    end else begin
                        n_pend = r_acc[6:0];
                        n_pcnt = r_cnt[2:0];
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // release the held byte as the last of the item
                if (r_hold_valid) begin
                    w_push       = '{valid: 1'b1, data: r_hold_byte, last: 1'b1};
                    n_hold_valid = 1'b0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hold each byte back one step so the last one can be marked
        if (w_emit) begin
            if (r_hold_valid) begin
                w_push = '{valid: 1'b1, data: r_hold_byte, last: 1'b0};
            end
            n_hold_valid = 1'b1;
            n_hold_byte  = w_emit_byte;
        end
    end

`include "lzw_compressor_macros.svh"

    `LZW_ASSERT_NOW(a_hold_empty_on_accept, i_clk, i_rst_n, w_accept, !r_hold_valid)
    `LZW_ASSERT_NOW(a_width_range, i_clk, i_rst_n, 1'b1,
        (r_code_width >= WIDTH_INIT) && (r_code_width <= WIDTH_MAX))
    `LZW_ASSERT_NOW(a_code_in_width, i_clk, i_rst_n, 1'b1,
        (r_next_code >= FIRST_FREE) && (r_next_code <= (NEXT_W'(1) << r_code_width)))
    `LZW_ASSERT_NEXT(a_probe_follows, i_clk, i_rst_n, w_child_re, w_entry_re)
    `LZW_ASSERT_NOW(a_write_on_miss, i_clk, i_rst_n, w_dict_we, r_state == ST_VERIFY)
endmodule
